// File: hw/rtl/positional_shift_list_core_assert.svh
// Assertion macros for the positional shift list core.
// Included by the top level; expects signals named clk and rst in scope.
`ifndef POSITIONAL_SHIFT_LIST_CORE_ASSERT_SVH
`define POSITIONAL_SHIFT_LIST_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSL_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/psl_pkg.sv
// Shared types and constants of the positional shift list core.
// No dependencies; used by the interfaces' users, the cell and the top level.
`timescale 1ns / 1ps

package psl_pkg;

  // Width of internal positions and counts; covers a capacity of up to 127.
  localparam int POS_W       = 7;
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = 5;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_FIND       = 3'd6,
    CMD_READ_ALL   = 3'd7
  } cmd_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_POS   = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_OPEN,
    CELL_CLOSE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               match_found;
    logic [3:0]         match_index;
    logic signed [31:0] element_value;
    logic [4:0]         element_count;
    logic               last_result;
  } rsp_t;

endpackage

// File: hw/rtl/psl_req_if.sv
// Command channel of the positional shift list core.
// Valid/ready handshake with the command payload; no dependencies.
`timescale 1ns / 1ps

interface psl_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [3:0]         position;
  logic signed [31:0] item_value;

  modport source (output valid, cmd, position, item_value, input ready);
  modport sink (input valid, cmd, position, item_value, output ready);
endinterface

// File: hw/rtl/psl_rsp_if.sv
// Result channel of the positional shift list core.
// Valid/ready handshake with the result payload; no dependencies.
`timescale 1ns / 1ps

interface psl_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               match_found;
  logic [3:0]         match_index;
  logic signed [31:0] element_value;
  logic [4:0]         element_count;
  logic               last_result;

  modport source (output valid, status, match_found, match_index, element_value,
                  element_count, last_result, input ready);
  modport sink (input valid, status, match_found, match_index, element_value,
                element_count, last_result, output ready);
endinterface

// File: hw/rtl/psl_cell.sv
// One storage cell of the shift list chain.
// Depends on psl_pkg for the cell control struct.
`timescale 1ns / 1ps

module psl_cell import psl_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int INDEX     = 0
) (
  input  logic                        clk,
  input  cell_ctrl_t                  ctrl,
  input  logic signed [WORD_BITS-1:0] new_word,
  input  logic signed [WORD_BITS-1:0] key,
  input  logic signed [WORD_BITS-1:0] below,
  input  logic signed [WORD_BITS-1:0] above,
  output logic signed [WORD_BITS-1:0] value,
  output logic                        match
);

  localparam logic [POS_W-1:0] MyIndex = POS_W'(INDEX);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_OPEN: begin
        // Cells above the gap take their lower neighbor; the gap takes the new word.
        if (MyIndex > ctrl.pos) begin
          value <= below;
        end else if (MyIndex == ctrl.pos) begin
          value <= new_word;
        end
      end
      CELL_CLOSE: begin
        if (MyIndex >= ctrl.pos) begin
          value <= above;
        end
      end
      CELL_ROTATE: begin
        value <= above;
      end
      default: begin
      end
    endcase
  end

  assign match = (value == key);

endmodule

// File: hw/rtl/positional_shift_list_core.sv
// Positional shift list core: top level with control and the chain of cells.
// Depends on psl_pkg, psl_req_if, psl_rsp_if, psl_cell and the assertion header.
`timescale 1ns / 1ps

// The list lives in a row of CAPACITY cells that all shift in the same cycle. A
// command is accepted whenever the block is idle and the result register is empty
// or being emptied. Push, pop, insert and erase give a single result that is
// registered and appears in the next cycle. A find with no match and a read-all of
// an empty list also answer with one result in the next cycle. A find with at
// least one match and a read-all of a non-empty list rotate the whole row once
// through cell 0, one step per cycle while no result waits on the result channel;
// the next command is accepted once the rotation has restored the original order.

module positional_shift_list_core import psl_pkg::*; #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input logic      clk,
  input logic      rst,
  psl_req_if.sink  req,
  psl_rsp_if.source rsp
);

  `include "positional_shift_list_core_assert.svh"

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW-1:0]    LastStep = IW'(CAPACITY - 1);
  localparam logic [POS_W-1:0] CapPos   = POS_W'(CAPACITY);

  state_t state, state_next;

  logic [CW-1:0]       count;
  logic [IW-1:0]       step;
  logic [RES_W-1:0]    nres;
  logic [CAPACITY-1:0] mvec;
  logic                scan_find;
  logic                rsp_valid;
  rsp_t                rsp_q;

  logic signed [WORD_BITS-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]         cell_match;
  logic signed [WORD_BITS-1:0] key_in;
  cell_ctrl_t                  cell_ctrl;

  logic             out_free;
  logic             acc;
  logic             advance;
  logic [POS_W-1:0] cnt_pos;
  logic [POS_W-1:0] req_pos;
  logic [CAPACITY-1:0] mvec_in;

  // Decoded command
  cell_op_t         dec_op;
  logic [POS_W-1:0] dec_pos;
  logic [CW-1:0]    dec_count;
  logic [1:0]       dec_status;
  logic             dec_scan;
  logic             dec_find;

  // Scan step
  logic emit, emit_find, emit_read, last_find, last_read;

  assign key_in   = WORD_BITS'(req.item_value);
  assign cnt_pos  = POS_W'(count);
  assign req_pos  = POS_W'(req.position);
  assign out_free = !rsp_valid || rsp.ready;
  assign acc      = req.valid && req.ready;

  // Cell chain; the top cell wraps to cell 0 for the read-out rotation.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_BITS-1:0] below;
    logic signed [WORD_BITS-1:0] above;
    if (i == 0) begin : g_first
      assign below = '0;
    end else begin : g_mid_lo
      assign below = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign above = cell_value[0];
    end else begin : g_mid_hi
      assign above = cell_value[i+1];
    end
    psl_cell #(
      .WORD_BITS(WORD_BITS),
      .INDEX    (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .new_word(key_in),
      .key     (key_in),
      .below   (below),
      .above   (above),
      .value   (cell_value[i]),
      .match   (cell_match[i])
    );
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      mvec_in[i] = cell_match[i] && (POS_W'(i) < cnt_pos);
    end
  end

  always_comb begin
    dec_op     = CELL_HOLD;
    dec_pos    = '0;
    dec_count  = count;
    dec_status = ST_OK;
    dec_scan   = 1'b0;
    dec_find   = 1'b0;
    case (req.cmd)
      CMD_PUSH_BACK: begin
        if (cnt_pos >= CapPos) begin
          dec_status = ST_FULL;
        end else begin
          dec_op    = CELL_OPEN;
          dec_pos   = cnt_pos;
          dec_count = CW'(count + 1'b1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (cnt_pos >= CapPos) begin
          dec_status = ST_FULL;
        end else begin
          dec_op    = CELL_OPEN;
          dec_count = CW'(count + 1'b1);
        end
      end
      CMD_POP_BACK: begin
        if (count == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_count = CW'(count - 1'b1);
        end
      end
      CMD_POP_FRONT: begin
        if (count == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_op    = CELL_CLOSE;
          dec_count = CW'(count - 1'b1);
        end
      end
      CMD_INSERT: begin
        if (cnt_pos >= CapPos) begin
          dec_status = ST_FULL;
        end else if (req_pos > cnt_pos) begin
          dec_status = ST_POS;
        end else begin
          dec_op    = CELL_OPEN;
          dec_pos   = req_pos;
          dec_count = CW'(count + 1'b1);
        end
      end
      CMD_ERASE: begin
        if (count == '0) begin
          dec_status = ST_EMPTY;
        end else if (req_pos >= cnt_pos) begin
          dec_status = ST_POS;
        end else begin
          dec_op    = CELL_CLOSE;
          dec_pos   = req_pos;
          dec_count = CW'(count - 1'b1);
        end
      end
      CMD_FIND: begin
        // Without any match the single no-match result is given at once.
        dec_find = 1'b1;
        dec_scan = (mvec_in != '0);
      end
      CMD_READ_ALL: begin
        if (count == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_scan = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // During a scan, cell 0 holds the entry whose index equals the step count.
  assign emit_find = mvec[0] && (nres < RES_W'(MAX_RESULTS));
  assign last_find = (mvec[CAPACITY-1:1] == '0) || (nres == RES_W'(MAX_RESULTS - 1));
  assign emit_read = (POS_W'(step) < cnt_pos) && (nres < RES_W'(MAX_RESULTS));
  assign last_read = (POS_W'(POS_W'(step) + POS_W'(1)) == cnt_pos)
                  || (nres == RES_W'(MAX_RESULTS - 1));
  assign emit      = scan_find ? emit_find : emit_read;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc && dec_scan) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (advance && (step == LastStep)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req.ready     = 1'b0;
    advance       = 1'b0;
    cell_ctrl.op  = CELL_HOLD;
    cell_ctrl.pos = '0;
    case (state)
      S_IDLE: begin
        req.ready = out_free;
        if (req.valid && out_free) begin
          cell_ctrl.op  = dec_op;
          cell_ctrl.pos = dec_pos;
        end
      end
      S_SCAN: begin
        advance = !emit || out_free;
        if (advance) begin
          cell_ctrl.op = CELL_ROTATE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (acc) begin
        count <= dec_count;
      end
      if ((acc && !dec_scan) || (advance && emit)) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && dec_scan) begin
      step      <= '0;
      nres      <= '0;
      mvec      <= mvec_in;
      scan_find <= dec_find;
    end else if (advance) begin
      step <= IW'(step + 1'b1);
      nres <= RES_W'(nres + RES_W'(emit));
      mvec <= mvec >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !dec_scan) begin
      rsp_q.status        <= dec_status;
      rsp_q.match_found   <= 1'b0;
      rsp_q.match_index   <= '0;
      rsp_q.element_value <= '0;
      rsp_q.element_count <= 5'(dec_count);
      rsp_q.last_result   <= 1'b1;
    end else if (advance && emit) begin
      rsp_q.status        <= ST_OK;
      rsp_q.match_found   <= scan_find;
      rsp_q.match_index   <= 4'(step);
      rsp_q.element_value <= scan_find ? 32'sd0 : 32'(cell_value[0]);
      rsp_q.element_count <= 5'(count);
      rsp_q.last_result   <= scan_find ? last_find : last_read;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_q.status;
  assign rsp.match_found   = rsp_q.match_found;
  assign rsp.match_index   = rsp_q.match_index;
  assign rsp.element_value = rsp_q.element_value;
  assign rsp.element_count = rsp_q.element_count;
  assign rsp.last_result   = rsp_q.last_result;

  `PSL_ASSERT_SAME(a_count_bound, 1'b1, cnt_pos <= CapPos, "element count above capacity")
  `PSL_ASSERT_SAME(a_no_accept_in_scan, state == S_SCAN, !req.ready,
                   "command accepted during a scan")
  `PSL_ASSERT_NEXT(a_full_push, acc && (req.cmd == CMD_PUSH_BACK) && (cnt_pos == CapPos),
                   rsp_valid && (rsp_q.status == ST_FULL) && (cnt_pos == CapPos),
                   "push on a full list not reported")
  `PSL_ASSERT_NEXT(a_scan_end, (state == S_SCAN) && advance && (step == LastStep),
                   state == S_IDLE, "scan did not end after a full rotation")

endmodule
